@@ rtl/tm_pkg.sv @@
package tm_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int SIDE_W = 46;
	localparam int PERIM_W = 48;
	localparam int DIFF_W = 47;
	localparam int AREA_W = 63;
	localparam int CFG_W = 64;
	localparam int ADDR_W = 4;

	localparam logic REG_MIN_LEN = 1'b0;
	localparam logic REG_MAX_LEN = 1'b1;

	typedef enum logic [1:0] {
		ST_OK,
		ST_RANGE,
		ST_NOT_TRI
	} tm_status_t;

	typedef struct packed {
		logic [SIDE_W-1:0] side_a;
		logic [SIDE_W-1:0] side_b;
		logic [SIDE_W-1:0] side_c;
	} tm_in_t;

	typedef struct packed {
		tm_status_t status;
		logic [PERIM_W-1:0] perim;
		logic [AREA_W-1:0] tri_area;
		logic [SIDE_W-1:0] height_a;
		logic [SIDE_W-1:0] height_b;
		logic [SIDE_W-1:0] height_c;
		logic [SIDE_W-1:0] median_a;
		logic [SIDE_W-1:0] median_b;
		logic [SIDE_W-1:0] median_c;
		logic [SIDE_W-1:0] bisector_a;
		logic [SIDE_W-1:0] bisector_b;
		logic [SIDE_W-1:0] bisector_c;
	} tm_out_t;

endpackage

@@ rtl/tm_delay.sv @@
module tm_delay #(
	parameter int W = 8,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	if (DEPTH == 0) begin : g_wire
		assign q = d;
	end else begin : g_line
		logic [W-1:0] line_s [DEPTH];

		always_ff @(posedge clk) begin
			line_s[0] <= d;
			for (int k = 1; k < DEPTH; k++) begin
				line_s[k] <= line_s[k-1];
			end
		end

		assign q = line_s[DEPTH-1];
	end

endmodule

@@ rtl/tm_mul.sv @@
module tm_mul #(
	parameter int A_W = 8,
	parameter int B_W = 8
) (
	input  logic               clk,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic [A_W+B_W-1:0] p
);

	localparam int P_W = A_W + B_W;

	logic [A_W-1:0] a_s   [B_W-1];
	logic [B_W-1:0] b_s   [B_W-1];
	logic [P_W-1:0] acc_s [B_W];

	// one multiplier bit per stage
	always_ff @(posedge clk) begin
		a_s[0] <= a;
		b_s[0] <= b;
		acc_s[0] <= b[0] ? P_W'(a) : P_W'(0);
		for (int k = 1; k < B_W - 1; k++) begin
			a_s[k] <= a_s[k-1];
			b_s[k] <= b_s[k-1];
		end
		for (int k = 1; k < B_W; k++) begin
			acc_s[k] <= acc_s[k-1] + (b_s[k-1][k] ? (P_W'(a_s[k-1]) << k) : P_W'(0));
		end
	end

	assign p = acc_s[B_W-1];

endmodule

@@ rtl/tm_sqrt.sv @@
module tm_sqrt #(
	parameter int IN_W = 16
) (
	input  logic                  clk,
	input  logic [IN_W-1:0]       x,
	output logic [(IN_W+1)/2-1:0] r
);

	localparam int R_W = (IN_W + 1) / 2;

	logic [2*R_W-1:0] x_ext;
	logic [2*R_W-1:0] x_s    [R_W-1];
	logic [R_W+2:0]   rem_s  [R_W-1];
	logic [R_W-1:0]   root_s [R_W];

	assign x_ext = (2*R_W)'(x);

	for (genvar k = 0; k < R_W; k++) begin : g_stage
		logic [R_W+2:0]   rem_in;
		logic [R_W-1:0]   root_in;
		logic [2*R_W-1:0] x_in;
		logic [R_W+2:0]   rem_sh;
		logic [R_W+2:0]   trial;
		logic             fit;

		if (k == 0) begin : g_head
			assign rem_in = '0;
			assign root_in = '0;
			assign x_in = x_ext;
		end else begin : g_body
			assign rem_in = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign x_in = x_s[k-1];
		end

		assign rem_sh = {rem_in[R_W:0], x_in[2*R_W-1 -: 2]};
		assign trial = {1'b0, root_in, 2'b01};
		assign fit = rem_sh >= trial;

		always_ff @(posedge clk) begin
			root_s[k] <= {root_in[R_W-2:0], fit};
		end

		if (k < R_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k] <= fit ? rem_sh - trial : rem_sh;
				x_s[k] <= x_in << 2;
			end
		end
	end

	assign r = root_s[R_W-1];

endmodule

@@ rtl/tm_div.sv @@
module tm_div #(
	parameter int N_W = 16,
	parameter int D_W = 8,
	parameter int Q_W = 8
) (
	input  logic           clk,
	input  logic [N_W-1:0] n,
	input  logic [D_W-1:0] d,
	output logic [Q_W-1:0] q
);

	logic [D_W-1:0] rem_s [Q_W-1];
	logic [Q_W-1:0] low_s [Q_W-1];
	logic [D_W-1:0] d_s   [Q_W-1];
	logic [Q_W-1:0] q_s   [Q_W];

	// quotient is known to fit Q_W bits
	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [D_W-1:0] rem_in;
		logic [Q_W-1:0] low_in;
		logic [D_W-1:0] d_in;
		logic [Q_W-1:0] q_in;
		logic [D_W:0]   rem_sh;
		logic [D_W:0]   diff;
		logic           fit;

		if (k == 0) begin : g_head
			assign rem_in = D_W'(n >> Q_W);
			assign low_in = n[Q_W-1:0];
			assign d_in = d;
			assign q_in = '0;
		end else begin : g_body
			assign rem_in = rem_s[k-1];
			assign low_in = low_s[k-1];
			assign d_in = d_s[k-1];
			assign q_in = q_s[k-1];
		end

		assign rem_sh = {rem_in, low_in[Q_W-1]};
		assign diff = rem_sh - {1'b0, d_in};
		assign fit = rem_sh >= {1'b0, d_in};

		always_ff @(posedge clk) begin
			q_s[k] <= {q_in[Q_W-2:0], fit};
		end

		if (k < Q_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k] <= fit ? diff[D_W-1:0] : rem_sh[D_W-1:0];
				low_s[k] <= low_in << 1;
				d_s[k] <= d_in;
			end
		end
	end

	assign q = q_s[Q_W-1];

endmodule

@@ rtl/triangle_metrics.sv @@
// channel   direction  transfer                      payload
// sides     in         start high, busy low at edge  tm_in_t
// result    out        done high for one cycle       tm_out_t
// config    in         psel, penable, pwrite, pready 64-bit register
//
// One triangle enters per cycle; busy stays low.
// Latency from accept to done is set by the product chain, the 95-bit root
// of 16*area^2 and the height divide.
// Reset clears the valid line and loads the default length limits.
// Results cannot be held off, so the pipeline never stalls.
module triangle_metrics #(
	parameter int FRAC_BITS = tm_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  tm_pkg::tm_in_t              sides,
	output logic                        done,
	output tm_pkg::tm_out_t             result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tm_pkg::ADDR_W-1:0]   paddr,
	input  logic [tm_pkg::CFG_W-1:0]    pwdata,
	output logic [tm_pkg::CFG_W-1:0]    prdata,
	output logic                        pready
);

	import tm_pkg::*;

	localparam longint unsigned SIDE_MAX = (64'd1 << SIDE_W) - 64'd1;
	localparam longint unsigned MAX_RAW = 64'd1000000000 << FRAC_BITS;
	localparam longint unsigned MAX_RST = (MAX_RAW > SIDE_MAX) ? SIDE_MAX : MAX_RAW;
	localparam longint unsigned MIN_RST = ((64'd1 << FRAC_BITS) + 64'd9999) / 64'd10000;

	localparam int SQ_W = 2 * SIDE_W;
	localparam int PP_W = PERIM_W + DIFF_W;
	localparam int Q12_W = 2 * DIFF_W;
	localparam int PROD_W = PP_W + Q12_W;
	localparam int ROOT_W = (PROD_W + 1) / 2;
	localparam int XB_W = PP_W + SQ_W;
	localparam int XBR_W = (XB_W + 1) / 2;
	localparam int MED_W = SQ_W + 2;
	localparam int MEDR_W = (MED_W + 1) / 2;
	localparam int AIN_W = PROD_W - (4 * FRAC_BITS - 4);
	localparam int AR_W = (AIN_W + 1) / 2;

	localparam int T_YZ = SIDE_W;
	localparam int T_PP = DIFF_W;
	localparam int T_PROD = T_PP + Q12_W;
	localparam int T_ROOT = T_PROD + ROOT_W;
	localparam int T_AREA = T_PROD + AR_W;
	localparam int T_END = T_ROOT + SIDE_W;
	localparam int T_XBR = T_PP + SQ_W + XBR_W;
	localparam int T_BIS = T_XBR + SIDE_W;
	localparam int T_MED = SIDE_W + 1 + MEDR_W;

	logic [SIDE_W-1:0] min_q;
	logic [SIDE_W-1:0] max_q;
	logic              cfg_wr;

	logic [SIDE_W-1:0] side_in [3];
	logic              range_bad;
	logic              tri_bad;
	tm_status_t        status_nx;

	logic              vld_s1;
	tm_status_t        status_s1;
	logic [SIDE_W-1:0] side_s1 [3];

	logic              vld_s2;
	tm_status_t        status_s2;
	logic [SIDE_W-1:0] side_s2 [3];
	logic [PERIM_W-1:0] perim_s2;
	logic [DIFF_W-1:0] d_s2    [3];
	logic [DIFF_W-1:0] syz_s2  [3];
	logic [DIFF_W-1:0] tx_s2   [3];

	logic [T_END-1:0]  vld_line_q;
	logic [1:0]        status_d;
	logic [PERIM_W-1:0] perim_d;

	logic [Q12_W-1:0]  q12;
	logic [PROD_W-1:0] prod;
	logic [ROOT_W-1:0] root;
	logic [AR_W-1:0]   area_root;
	logic [AR_W-1:0]   area_d;
	logic [127:0]      area_ext;
	logic [AREA_W-1:0] area_sat;

	logic [SQ_W-1:0]   sq      [3];
	logic [PP_W-1:0]   pp      [3];
	logic [SQ_W-1:0]   yz      [3];
	logic [SQ_W-1:0]   yz_d    [3];
	logic [XB_W-1:0]   xb      [3];
	logic [XBR_W-1:0]  xbr     [3];
	logic [DIFF_W-1:0] syz_d   [3];
	logic [SIDE_W-1:0] bis     [3];
	logic [SIDE_W-1:0] bis_d   [3];
	logic [DIFF_W-1:0] tx_d    [3];
	logic [SIDE_W-1:0] hgt     [3];
	logic [MED_W-1:0]  med_arg_q [3];
	logic [MEDR_W-1:0] medr    [3];
	logic [SIDE_W-1:0] med_d   [3];

	tm_out_t           result_nx;
	tm_out_t           result_q;
	logic              done_q;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= SIDE_W'(MIN_RST);
			max_q <= SIDE_W'(MAX_RST);
		end else if (cfg_wr) begin
			unique case (paddr[3])
				REG_MIN_LEN: min_q <= pwdata[SIDE_W-1:0];
				REG_MAX_LEN: max_q <= pwdata[SIDE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			REG_MIN_LEN: prdata = CFG_W'(min_q);
			REG_MAX_LEN: prdata = CFG_W'(max_q);
			default: prdata = '0;
		endcase
	end

	// checks
	assign busy = 1'b0;
	assign side_in[0] = sides.side_a;
	assign side_in[1] = sides.side_b;
	assign side_in[2] = sides.side_c;

	always_comb begin
		range_bad = 1'b0;
		tri_bad = 1'b0;
		for (int i = 0; i < 3; i++) begin
			range_bad = range_bad || (side_in[i] < min_q) || (side_in[i] > max_q);
			tri_bad = tri_bad || (({1'b0, side_in[(i+1)%3]} + {1'b0, side_in[(i+2)%3]})
				<= {1'b0, side_in[i]});
		end
		if (range_bad) begin
			status_nx = ST_RANGE;
		end else if (tri_bad) begin
			status_nx = ST_NOT_TRI;
		end else begin
			status_nx = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_line_q <= '0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_line_q <= {vld_line_q[T_END-2:0], vld_s2};
			done_q <= vld_line_q[T_END-1];
		end
	end

	always_ff @(posedge clk) begin
		status_s1 <= status_nx;
		status_s2 <= status_s1;
		for (int i = 0; i < 3; i++) begin
			side_s1[i] <= side_in[i];
			side_s2[i] <= side_s1[i];
			d_s2[i] <= DIFF_W'({1'b0, side_s1[(i+1)%3]} + {1'b0, side_s1[(i+2)%3]}
				- {1'b0, side_s1[i]});
			syz_s2[i] <= {1'b0, side_s1[(i+1)%3]} + {1'b0, side_s1[(i+2)%3]};
			tx_s2[i] <= {side_s1[i], 1'b0};
		end
		perim_s2 <= PERIM_W'(side_s1[0]) + PERIM_W'(side_s1[1]) + PERIM_W'(side_s1[2]);
	end

	tm_delay #(.W(2), .DEPTH(T_END)) u_status_dly (
		.clk(clk), .d(status_s2), .q(status_d)
	);

	tm_delay #(.W(PERIM_W), .DEPTH(T_END)) u_perim_dly (
		.clk(clk), .d(perim_s2), .q(perim_d)
	);

	// area and the shared root of 16*area^2
	tm_mul #(.A_W(DIFF_W), .B_W(DIFF_W)) u_q12 (
		.clk(clk), .a(d_s2[1]), .b(d_s2[2]), .p(q12)
	);

	tm_mul #(.A_W(PP_W), .B_W(Q12_W)) u_prod (
		.clk(clk), .a(pp[0]), .b(q12), .p(prod)
	);

	tm_sqrt #(.IN_W(PROD_W)) u_root (
		.clk(clk), .x(prod), .r(root)
	);

	tm_sqrt #(.IN_W(AIN_W)) u_area (
		.clk(clk), .x(prod[PROD_W-1 -: AIN_W]), .r(area_root)
	);

	tm_delay #(.W(AR_W), .DEPTH(T_END - T_AREA)) u_area_dly (
		.clk(clk), .d(area_root), .q(area_d)
	);

	assign area_ext = 128'(area_d);
	assign area_sat = (area_ext[127:AREA_W] != '0) ? '1 : area_ext[AREA_W-1:0];

	for (genvar i = 0; i < 3; i++) begin : g_side
		localparam int IY = (i + 1) % 3;
		localparam int IZ = (i + 2) % 3;

		tm_mul #(.A_W(SIDE_W), .B_W(SIDE_W)) u_sq (
			.clk(clk), .a(side_s2[i]), .b(side_s2[i]), .p(sq[i])
		);

		tm_mul #(.A_W(PERIM_W), .B_W(DIFF_W)) u_pp (
			.clk(clk), .a(perim_s2), .b(d_s2[i]), .p(pp[i])
		);

		tm_mul #(.A_W(SIDE_W), .B_W(SIDE_W)) u_yz (
			.clk(clk), .a(side_s2[IY]), .b(side_s2[IZ]), .p(yz[i])
		);

		tm_delay #(.W(SQ_W), .DEPTH(T_PP - T_YZ)) u_yz_dly (
			.clk(clk), .d(yz[i]), .q(yz_d[i])
		);

		tm_mul #(.A_W(PP_W), .B_W(SQ_W)) u_xb (
			.clk(clk), .a(pp[i]), .b(yz_d[i]), .p(xb[i])
		);

		tm_sqrt #(.IN_W(XB_W)) u_xbr (
			.clk(clk), .x(xb[i]), .r(xbr[i])
		);

		tm_delay #(.W(DIFF_W), .DEPTH(T_XBR)) u_syz_dly (
			.clk(clk), .d(syz_s2[i]), .q(syz_d[i])
		);

		tm_div #(.N_W(XBR_W), .D_W(DIFF_W), .Q_W(SIDE_W)) u_bis (
			.clk(clk), .n(xbr[i]), .d(syz_d[i]), .q(bis[i])
		);

		tm_delay #(.W(SIDE_W), .DEPTH(T_END - T_BIS)) u_bis_dly (
			.clk(clk), .d(bis[i]), .q(bis_d[i])
		);

		tm_delay #(.W(DIFF_W), .DEPTH(T_ROOT)) u_tx_dly (
			.clk(clk), .d(tx_s2[i]), .q(tx_d[i])
		);

		tm_div #(.N_W(ROOT_W), .D_W(DIFF_W), .Q_W(SIDE_W)) u_hgt (
			.clk(clk), .n(root), .d(tx_d[i]), .q(hgt[i])
		);

		always_ff @(posedge clk) begin
			med_arg_q[i] <= MED_W'({sq[IY], 1'b0}) + MED_W'({sq[IZ], 1'b0})
				- MED_W'(sq[i]);
		end

		tm_sqrt #(.IN_W(MED_W)) u_med (
			.clk(clk), .x(med_arg_q[i]), .r(medr[i])
		);

		tm_delay #(.W(SIDE_W), .DEPTH(T_END - T_MED)) u_med_dly (
			.clk(clk), .d(medr[i][MEDR_W-1:1]), .q(med_d[i])
		);
	end

	// drop the metrics of a rejected item
	always_comb begin
		result_nx = '0;
		result_nx.status = tm_status_t'(status_d);
		if (status_d == ST_OK) begin
			result_nx.perim = perim_d;
			result_nx.tri_area = area_sat;
			result_nx.height_a = hgt[0];
			result_nx.height_b = hgt[1];
			result_nx.height_c = hgt[2];
			result_nx.median_a = med_d[0];
			result_nx.median_b = med_d[1];
			result_nx.median_c = med_d[2];
			result_nx.bisector_a = bis_d[0];
			result_nx.bisector_b = bis_d[1];
			result_nx.bisector_c = bis_d[2];
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_nx;
	end

	assign done = done_q;
	assign result = result_q;

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(T_END + 3) done)
		else $error("transfer did not complete at fixed latency");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |-> (result.perim == '0 && result.tri_area == '0))
		else $error("rejected item carries metrics");

	a_done_from_line: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_line_q[T_END-1]))
		else $error("strobe without valid item");

endmodule
